// File: sv/mclw_pkg.sv
package mclw_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int CPU_W      = 3;
    localparam int TIME_W     = 32;
    localparam int TASK_W     = 22;
    localparam int THRESH_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Every third tick of a CPU checks its neighbour.
    localparam int TICK_PERIOD = 3;
    localparam int PHASE_W     = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd10;

    typedef logic [CPU_W-1:0]  cpu_t;
    typedef logic [TIME_W-1:0] stamp_t;
    typedef logic [TASK_W-1:0] task_t;

    typedef enum logic [2:0] {
        FN_TICK       = 3'd0,
        FN_SOFT_TOUCH = 3'd1,
        FN_TOUCH_ALL  = 3'd2,
        FN_NMI_TOUCH  = 3'd3,
        FN_THREAD_RUN = 3'd4,
        FN_ONLINE     = 3'd5,
        FN_OFFLINE    = 3'd6
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD     = 2'd0,
        CFG_SOFT_PANIC    = 2'd1,
        CFG_HARD_PANIC    = 2'd2,
        CFG_BACKTRACE_ALL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] func;
        cpu_t       cpu_index;
        stamp_t     now_seconds;
        task_t      task_id;
        logic       guest_paused;
    } item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic                soft_panic_en;
        logic                hard_panic_en;
        logic                backtrace_all_en;
    } cfg_t;

    typedef struct packed {
        logic   hard_lockup;
        cpu_t   hard_cpu;
        logic   hard_panic;
        logic   soft_lockup;
        stamp_t soft_duration;
        logic   soft_panic;
        logic   backtrace_all;
    } result_t;

    typedef struct packed {
        logic found;
        cpu_t idx;
    } nb_t;

    // Next online CPU after c, wrapping, excluding c itself.
    function automatic nb_t next_online(input logic [NUM_CPUS-1:0] mask, input cpu_t c);
        nb_t               nb;
        logic [CPU_W:0]    k;
        nb.found = 1'b0;
        nb.idx   = '0;
        // Walk from the farthest neighbour down so the nearest one wins.
        for (int i = NUM_CPUS - 1; i >= 1; i--) begin
            k = {1'b0, c} + (CPU_W + 1)'(i);
            if (k >= (CPU_W + 1)'(NUM_CPUS)) begin
                k = k - (CPU_W + 1)'(NUM_CPUS);
            end
            if (mask[k[CPU_W-1:0]]) begin
                nb.found = 1'b1;
                nb.idx   = k[CPU_W-1:0];
            end
        end
        return nb;
    endfunction

endpackage

// File: sv/multi_cpu_lockup_watchdog.sv
// Each accepted event is captured in the input register; its result is registered in the
// result register when the output register is free, not while a stalled result holds it.
// Throughput: one event per cycle while in_stall is low; the per-CPU state is read and updated
// in one pass between the input register and the result register.
// Reset (rst_n, asynchronous, active low) clears all per-CPU state, marks every CPU
// offline, clears the panic and backtrace enables and sets the threshold to 10 seconds.
module multi_cpu_lockup_watchdog (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     func,
    input  mclw_pkg::cpu_t                 cpu_index,
    input  mclw_pkg::stamp_t               now_seconds,
    input  mclw_pkg::task_t                task_id,
    input  logic                           guest_paused,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hard_lockup,
    output mclw_pkg::cpu_t                 hard_cpu,
    output logic                           hard_panic,
    output logic                           soft_lockup,
    output mclw_pkg::stamp_t               soft_duration,
    output logic                           soft_panic,
    output logic                           backtrace_all,
    input  logic                           cfg_we,
    input  logic [mclw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mclw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mclw_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    s1_valid_reg, s1_valid_next;
    item_t   item_reg;
    logic    o_valid_reg, o_valid_next;
    result_t res_reg;
    result_t result;
    logic    out_free;
    logic    s1_go;
    logic    in_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD:     cfg_next.threshold        = cfg_data[THRESH_W-1:0];
                CFG_SOFT_PANIC:    cfg_next.soft_panic_en    = cfg_data[0];
                CFG_HARD_PANIC:    cfg_next.hard_panic_en    = cfg_data[0];
                CFG_BACKTRACE_ALL: cfg_next.backtrace_all_en = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // The input register takes a transaction when it is empty or can hand its own
    // transaction on, so it can still take one while a result waits.
    assign out_free = !o_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (s1_go) begin
            o_valid_next = 1'b1;
        end else if (!out_stall) begin
            o_valid_next = 1'b0;
        end
    end

    mclw_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_go),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.threshold        <= THRESH_RESET;
            cfg_reg.soft_panic_en    <= 1'b0;
            cfg_reg.hard_panic_en    <= 1'b0;
            cfg_reg.backtrace_all_en <= 1'b0;
            s1_valid_reg             <= 1'b0;
            o_valid_reg              <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            item_reg.func         <= func;
            item_reg.cpu_index    <= cpu_index;
            item_reg.now_seconds  <= now_seconds;
            item_reg.task_id      <= task_id;
            item_reg.guest_paused <= guest_paused;
        end
        if (s1_go) begin
            res_reg <= result;
        end
    end

    assign out_valid     = o_valid_reg;
    assign hard_lockup   = res_reg.hard_lockup;
    assign hard_cpu      = res_reg.hard_cpu;
    assign hard_panic    = res_reg.hard_panic;
    assign soft_lockup   = res_reg.soft_lockup;
    assign soft_duration = res_reg.soft_duration;
    assign soft_panic    = res_reg.soft_panic;
    assign backtrace_all = res_reg.backtrace_all;

endmodule

// File: sv/mclw_engine.sv
module mclw_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mclw_pkg::item_t   item,
    input  mclw_pkg::cfg_t    cfg,
    output mclw_pkg::result_t result
);
    import mclw_pkg::*;

    stamp_t               soft_stamp_reg [NUM_CPUS];
    stamp_t               soft_stamp_next[NUM_CPUS];
    stamp_t               hard_stamp_reg [NUM_CPUS];
    stamp_t               hard_stamp_next[NUM_CPUS];
    stamp_t               tick_count_reg [NUM_CPUS];
    stamp_t               tick_count_next[NUM_CPUS];
    stamp_t               tick_seen_reg  [NUM_CPUS];
    stamp_t               tick_seen_next [NUM_CPUS];
    logic [PHASE_W-1:0]   tick_phase_reg [NUM_CPUS];
    logic [PHASE_W-1:0]   tick_phase_next[NUM_CPUS];
    task_t                last_task_reg  [NUM_CPUS];
    task_t                last_task_next [NUM_CPUS];
    logic [NUM_CPUS-1:0]  soft_warned_reg, soft_warned_next;
    logic [NUM_CPUS-1:0]  hard_warned_reg, hard_warned_next;
    logic [NUM_CPUS-1:0]  nmi_touched_reg, nmi_touched_next;
    logic [NUM_CPUS-1:0]  online_reg, online_next;

    cpu_t                 c;
    logic                 cpu_ok;
    nb_t                  nb;
    logic [NUM_CPUS-1:0]  seen_eq;
    logic [NUM_CPUS-1:0]  sync_sel;
    logic [8:0]           thresh_x6;
    logic [16:0]          thresh_prod;
    logic [6:0]           hard_thresh;
    logic [6:0]           soft_thresh;
    stamp_t               cnt_c;
    stamp_t               cnt_inc;
    logic [PHASE_W-1:0]   phase_inc;
    logic                 check_due;
    stamp_t               hard_d;
    logic                 hard_old;
    stamp_t               touch;
    stamp_t               soft_d;
    logic                 soft_late;

    assign c      = item.cpu_index;
    assign cpu_ok = int'(item.cpu_index) < NUM_CPUS;
    assign nb     = next_online(online_reg, c);

    // Tick counts are compared lane by lane so only the chosen bit is muxed.
    always_comb
    begin
        for (int k = 0; k < NUM_CPUS; k++) begin
            seen_eq[k] = tick_seen_reg[k] == tick_count_reg[k];
        end
    end

    // floor(6*t/5): 205/1024 is exact for every product below 1024.
    assign thresh_x6   = 9'(cfg.threshold) * 9'd6;
    assign thresh_prod = 17'(thresh_x6) * 17'd205;
    assign hard_thresh = thresh_prod[16:10];
    assign soft_thresh = {1'b0, cfg.threshold} << 1;

    assign cnt_c   = tick_count_reg[c];
    assign cnt_inc = cnt_c + 32'd1;

    // The phase follows the count modulo three, including the wrap to zero.
    always_comb
    begin
        if (cnt_c == '1) begin
            phase_inc = '0;
        end else if (tick_phase_reg[c] == PHASE_W'(TICK_PERIOD - 1)) begin
            phase_inc = '0;
        end else begin
            phase_inc = tick_phase_reg[c] + PHASE_W'(1);
        end
    end
    assign check_due = phase_inc == '0;

    assign hard_d   = item.now_seconds - hard_stamp_reg[nb.idx];
    assign hard_old = (hard_d != '0) && !hard_d[TIME_W-1] && (hard_d >= 32'(hard_thresh));

    assign touch     = soft_stamp_reg[c];
    assign soft_d    = item.now_seconds - (touch + 32'(soft_thresh));
    assign soft_late = (soft_d != '0) && !soft_d[TIME_W-1];

    always_comb
    begin
        soft_stamp_next  = soft_stamp_reg;
        hard_stamp_next  = hard_stamp_reg;
        tick_count_next  = tick_count_reg;
        tick_phase_next  = tick_phase_reg;
        last_task_next   = last_task_reg;
        soft_warned_next = soft_warned_reg;
        hard_warned_next = hard_warned_reg;
        nmi_touched_next = nmi_touched_reg;
        online_next      = online_reg;
        sync_sel         = '0;
        result           = '0;

        if (step && cpu_ok) begin
            case (item.func)
                FN_TICK:
                begin
                    tick_count_next[c] = cnt_inc;
                    tick_phase_next[c] = phase_inc;
                    if (cfg.threshold != '0) begin
                        if (check_due && nb.found) begin
                            if (nmi_touched_reg[nb.idx]) begin
                                nmi_touched_next[nb.idx] = 1'b0;
                            end else if (seen_eq[nb.idx] && hard_old) begin
                                if (!hard_warned_reg[nb.idx]) begin
                                    result.hard_lockup       = 1'b1;
                                    result.hard_cpu          = nb.idx;
                                    result.hard_panic        = cfg.hard_panic_en;
                                    hard_warned_next[nb.idx] = 1'b1;
                                end
                            end else begin
                                hard_warned_next[nb.idx] = 1'b0;
                                sync_sel[nb.idx]         = 1'b1;
                            end
                        end
                        // A zero soft stamp means freshly touched: restamp instead of checking.
                        if (touch == '0) begin
                            soft_stamp_next[c] = item.now_seconds;
                            hard_stamp_next[c] = item.now_seconds;
                        end else if (soft_late) begin
                            if (!item.guest_paused) begin
                                if (soft_warned_reg[c]) begin
                                    if (last_task_reg[c] != item.task_id) begin
                                        soft_warned_next[c] = 1'b0;
                                        soft_stamp_next[c]  = item.now_seconds;
                                        hard_stamp_next[c]  = item.now_seconds;
                                    end
                                end else begin
                                    last_task_next[c]    = item.task_id;
                                    result.soft_lockup   = 1'b1;
                                    result.soft_duration = item.now_seconds - touch;
                                    result.soft_panic    = cfg.soft_panic_en;
                                    result.backtrace_all = cfg.backtrace_all_en;
                                    soft_warned_next[c]  = 1'b1;
                                end
                            end
                        end else begin
                            soft_warned_next[c] = 1'b0;
                        end
                    end
                end
                FN_SOFT_TOUCH:
                begin
                    soft_stamp_next[c] = '0;
                end
                FN_TOUCH_ALL:
                begin
                    for (int k = 0; k < NUM_CPUS; k++) begin
                        if (online_reg[k]) begin
                            soft_stamp_next[k] = '0;
                        end
                    end
                end
                FN_NMI_TOUCH:
                begin
                    nmi_touched_next[c] = 1'b1;
                    soft_stamp_next[c]  = '0;
                end
                FN_THREAD_RUN:
                begin
                    soft_stamp_next[c] = item.now_seconds;
                    hard_stamp_next[c] = item.now_seconds;
                end
                FN_ONLINE:
                begin
                    nmi_touched_next[c] = 1'b1;
                    online_next[c]      = 1'b1;
                    soft_stamp_next[c]  = item.now_seconds;
                    hard_stamp_next[c]  = item.now_seconds;
                end
                FN_OFFLINE:
                begin
                    if (nb.found) begin
                        nmi_touched_next[nb.idx] = 1'b1;
                    end
                    online_next[c] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Each lane snapshots its own tick count when its hard check passes.
    always_comb
    begin
        tick_seen_next = tick_seen_reg;
        for (int k = 0; k < NUM_CPUS; k++) begin
            if (sync_sel[k]) begin
                tick_seen_next[k] = tick_count_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < NUM_CPUS; k++) begin
                soft_stamp_reg[k] <= '0;
                hard_stamp_reg[k] <= '0;
                tick_count_reg[k] <= '0;
                tick_seen_reg[k]  <= '0;
                tick_phase_reg[k] <= '0;
                last_task_reg[k]  <= '0;
            end
            soft_warned_reg <= '0;
            hard_warned_reg <= '0;
            nmi_touched_reg <= '0;
            online_reg      <= '0;
        end else if (step) begin
            soft_stamp_reg  <= soft_stamp_next;
            hard_stamp_reg  <= hard_stamp_next;
            tick_count_reg  <= tick_count_next;
            tick_seen_reg   <= tick_seen_next;
            tick_phase_reg  <= tick_phase_next;
            last_task_reg   <= last_task_next;
            soft_warned_reg <= soft_warned_next;
            hard_warned_reg <= hard_warned_next;
            nmi_touched_reg <= nmi_touched_next;
            online_reg      <= online_next;
        end
    end

endmodule

// File: tb/sv/tb_multi_cpu_lockup_watchdog.sv
`timescale 1ns / 100ps

module tb_multi_cpu_lockup_watchdog;
    import mclw_pkg::*;

    localparam logic [2:0] FN_UNUSED   = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;

    // Shadow of the per-CPU watchdog state; one expected report per event.
    class lockup_tracker;
        logic [THRESH_W-1:0] thresh;
        logic                soft_panic_on;
        logic                hard_panic_on;
        logic                bt_all_on;

        stamp_t              soft_mark[NUM_CPUS];
        stamp_t              hard_mark[NUM_CPUS];
        logic [31:0]         ticks[NUM_CPUS];
        logic [31:0]         ticks_at_check[NUM_CPUS];
        logic                soft_reported[NUM_CPUS];
        logic                hard_reported[NUM_CPUS];
        logic                nmi_flag[NUM_CPUS];
        task_t               task_at_report[NUM_CPUS];
        logic [NUM_CPUS-1:0] online;

        result_t             expected_reports[$];
        int                  mismatches;

        function new();
            thresh        = THRESH_RESET;
            soft_panic_on = 1'b0;
            hard_panic_on = 1'b0;
            bt_all_on     = 1'b0;
            online        = '0;
            mismatches    = 0;
            for (int k = 0; k < NUM_CPUS; k++) begin
                soft_mark[k]      = '0;
                hard_mark[k]      = '0;
                ticks[k]          = '0;
                ticks_at_check[k] = '0;
                soft_reported[k]  = 1'b0;
                hard_reported[k]  = 1'b0;
                nmi_flag[k]       = 1'b0;
                task_at_report[k] = '0;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void write_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_THRESHOLD:     thresh        = value[THRESH_W-1:0];
                CFG_SOFT_PANIC:    soft_panic_on = value[0];
                CFG_HARD_PANIC:    hard_panic_on = value[0];
                CFG_BACKTRACE_ALL: bt_all_on     = value[0];
                default: ;
            endcase
        endfunction

        // Wrapping time: a is later than b when the difference is positive as signed.
        function bit is_after(stamp_t a, stamp_t b);
            stamp_t d;
            d = a - b;
            return d != '0 && !d[TIME_W-1];
        endfunction

        function int unsigned next_up(int unsigned c);
            int unsigned k;
            for (int i = 1; i < NUM_CPUS; i++) begin
                k = (c + i) % NUM_CPUS;
                if (online[k])
                    return k;
            end
            return NUM_CPUS;
        endfunction

        function void restamp(int unsigned c, stamp_t now);
            soft_mark[c] = now;
            hard_mark[c] = now;
        endfunction

        function void on_tick(int unsigned c, stamp_t now, task_t tk, logic paused,
                              inout result_t r);
            stamp_t      last_touch;
            stamp_t      hlimit;
            stamp_t      slimit;
            stamp_t      soft_deadline;
            int unsigned n;
            last_touch = soft_mark[c];
            hlimit     = (6 * thresh) / 5;
            slimit     = 2 * thresh;
            ticks[c]   = ticks[c] + 1;
            if (thresh == '0)
                return;

            if (ticks[c] % TICK_PERIOD == 0) begin
                n = next_up(c);
                if (n < NUM_CPUS) begin
                    if (nmi_flag[n]) begin
                        nmi_flag[n] = 1'b0;
                    end
                    else if (ticks_at_check[n] == ticks[n] && is_after(now, hard_mark[n])
                             && (now - hard_mark[n]) >= hlimit) begin
                        if (!hard_reported[n]) begin
                            r.hard_lockup    = 1'b1;
                            r.hard_cpu       = cpu_t'(n);
                            r.hard_panic     = hard_panic_on;
                            hard_reported[n] = 1'b1;
                        end
                    end
                    else begin
                        hard_reported[n]  = 1'b0;
                        ticks_at_check[n] = ticks[n];
                    end
                end
            end

            // A zero soft stamp means the CPU was just touched.
            if (last_touch == '0) begin
                restamp(c, now);
                return;
            end

            soft_deadline = last_touch + slimit;
            if (is_after(now, soft_deadline)) begin
                if (paused)
                    return;
                if (soft_reported[c]) begin
                    if (task_at_report[c] != tk) begin
                        soft_reported[c] = 1'b0;
                        restamp(c, now);
                    end
                    return;
                end
                task_at_report[c] = tk;
                r.soft_lockup     = 1'b1;
                r.soft_duration   = now - last_touch;
                r.soft_panic      = soft_panic_on;
                r.backtrace_all   = bt_all_on;
                soft_reported[c]  = 1'b1;
            end
            else begin
                soft_reported[c] = 1'b0;
            end
        endfunction

        function void note_event(item_t ev);
            result_t     r;
            int unsigned c;
            int unsigned n;
            r = '0;
            c = int'(ev.cpu_index);
            case (ev.func)
                FN_TICK:       on_tick(c, ev.now_seconds, ev.task_id, ev.guest_paused, r);
                FN_SOFT_TOUCH: soft_mark[c] = '0;
                FN_TOUCH_ALL:
                    for (int k = 0; k < NUM_CPUS; k++)
                        if (online[k])
                            soft_mark[k] = '0;
                FN_NMI_TOUCH:
                begin
                    nmi_flag[c]  = 1'b1;
                    soft_mark[c] = '0;
                end
                FN_THREAD_RUN: restamp(c, ev.now_seconds);
                FN_ONLINE:
                begin
                    nmi_flag[c] = 1'b1;
                    online[c]   = 1'b1;
                    restamp(c, ev.now_seconds);
                end
                FN_OFFLINE:
                begin
                    n = next_up(c);
                    if (n < NUM_CPUS)
                        nmi_flag[n] = 1'b1;
                    online[c] = 1'b0;
                end
                default: ;
            endcase
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (expected_reports.size() == 0) begin
                $error("report arrived with no event outstanding");
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("hard_lockup", 32'(want.hard_lockup), 32'(got.hard_lockup));
            compare_field("hard_cpu", 32'(want.hard_cpu), 32'(got.hard_cpu));
            compare_field("hard_panic", 32'(want.hard_panic), 32'(got.hard_panic));
            compare_field("soft_lockup", 32'(want.soft_lockup), 32'(got.soft_lockup));
            compare_field("soft_duration", want.soft_duration, got.soft_duration);
            compare_field("soft_panic", 32'(want.soft_panic), 32'(got.soft_panic));
            compare_field("backtrace_all", 32'(want.backtrace_all), 32'(got.backtrace_all));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [2:0]            func          = '0;
    cpu_t                  cpu_index     = '0;
    stamp_t                now_seconds   = '0;
    task_t                 task_id       = '0;
    logic                  guest_paused  = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  hard_lockup;
    cpu_t                  hard_cpu;
    logic                  hard_panic;
    logic                  soft_lockup;
    stamp_t                soft_duration;
    logic                  soft_panic;
    logic                  backtrace_all;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    lockup_tracker tracker = new();

    int     send_idle_pct = 38;
    int     recv_idle_pct = 84;
    int     results_taken = 0;
    int     stall_hold    = 0;
    int     cycle_count   = 0;
    stamp_t wall          = '0;

    multi_cpu_lockup_watchdog uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .cpu_index     (cpu_index),
        .now_seconds   (now_seconds),
        .task_id       (task_id),
        .guest_paused  (guest_paused),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hard_lockup   (hard_lockup),
        .hard_cpu      (hard_cpu),
        .hard_panic    (hard_panic),
        .soft_lockup   (soft_lockup),
        .soft_duration (soft_duration),
        .soft_panic    (soft_panic),
        .backtrace_all (backtrace_all),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Observe configuration writes and both channels' transactions.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                tracker.write_config(cfg_idx_t'(cfg_index), cfg_data);
            if (in_valid && in_stall === 1'b0)
                tracker.note_event({func, cpu_index, now_seconds, task_id, guest_paused});
            if (out_valid === 1'b1 && !out_stall)
                tracker.check_report({hard_lockup, hard_cpu, hard_panic, soft_lockup,
                                      soft_duration, soft_panic, backtrace_all});
        end
    end

    // Result side: random stalls, plus two long hold-offs that back up the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_taken++;
            if (results_taken == 400 || results_taken == 800)
                stall_hold = 80;
        end
        if (stall_hold != 0) begin
            stall_hold--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_event(input logic [2:0] f, input int unsigned c, input stamp_t now,
                              input task_t tk, input logic paused);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        cpu_index    <= cpu_t'(c);
        now_seconds  <= now;
        task_id      <= tk;
        guest_paused <= paused;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic run_directed();
        send_event(FN_UNUSED, 0, 32'd0, '0, 1'b0);
        // Tick with no CPU online; the zero stamp is replaced by now.
        send_event(FN_TICK, 0, 32'd100, 22'd5, 1'b0);
        send_event(FN_ONLINE, 0, 32'd100, '0, 1'b0);
        send_event(FN_ONLINE, 7, 32'd100, '0, 1'b0);
        send_event(FN_TICK, 0, 32'd101, 22'd5, 1'b0);
        send_event(FN_TICK, 0, 32'd102, 22'd5, 1'b0);
        send_event(FN_TICK, 0, 32'd103, 22'd5, 1'b0);
        send_event(FN_TICK, 0, 32'd104, 22'd5, 1'b0);
        // Hard lockup on CPU 7 and soft lockup on CPU 0 in the same transaction.
        send_event(FN_TICK, 0, 32'd125, 22'd5, 1'b0);
        send_event(FN_TICK, 0, 32'd126, 22'd5, 1'b1);
        send_event(FN_TICK, 0, 32'd127, 22'd6, 1'b0);
        send_event(FN_THREAD_RUN, 7, 32'hFFFF_FFFF, 22'h3F_FFFF, 1'b0);
        send_event(FN_OFFLINE, 7, 32'd127, '0, 1'b0);
        // CPU 0 is now alone, so its check of a neighbour is skipped.
        send_event(FN_TICK, 0, 32'd128, 22'd6, 1'b0);
        send_event(FN_SOFT_TOUCH, 0, 32'd128, '0, 1'b0);
        send_event(FN_NMI_TOUCH, 3, 32'd128, '0, 1'b0);
        send_event(FN_TOUCH_ALL, 0, 32'd128, '0, 1'b0);
        // Soft lockup measured across the wrap of the time counter.
        send_event(FN_THREAD_RUN, 0, 32'hFFFF_FFF0, '0, 1'b0);
        send_event(FN_TICK, 0, 32'h0000_0010, 22'h3F_FFFF, 1'b0);
        send_event(FN_THREAD_RUN, 0, 32'h0000_0020, '0, 1'b0);
        send_event(FN_TICK, 0, 32'h0000_0040, 22'd7, 1'b1);
        send_event(FN_ONLINE, 7, 32'hFFFF_FFFF, '0, 1'b0);
        send_event(FN_TICK, 7, 32'd0, 22'h2A_AAAA, 1'b1);
        send_event(FN_TICK, 0, 32'h0000_0041, 22'h15_5555, 1'b0);
        in_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int thresh);
        logic [NUM_CPUS-1:0] busy;
        int                  pick;
        int unsigned         c;
        logic [2:0]          f;
        stamp_t              step;
        task_t               tk;
        busy = '0;
        wall = $urandom();
        for (int k = 0; k < NUM_CPUS; k++)
            if ($urandom_range(0, 3) != 0)
                send_event(FN_ONLINE, k, wall, '0, 1'b0);

        for (int n = 0; n < count; n++) begin
            // A few CPUs get most events so the others go quiet and look locked up.
            if (n % 64 == 0)
                busy = NUM_CPUS'($urandom());
            if (n == count / 2) begin
                in_valid <= 1'b0;
                wait_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 80)
                step = $urandom_range(0, 3);
            else if (pick < 97)
                step = $urandom_range(4, 3 * thresh + 5);
            else
                step = $urandom();
            wall = wall + step;

            if (busy != '0 && $urandom_range(0, 99) < 85) begin
                do
                    c = $urandom_range(0, NUM_CPUS - 1);
                while (!busy[c]);
            end
            else begin
                c = $urandom_range(0, NUM_CPUS - 1);
            end

            pick = $urandom_range(0, 99);
            if (pick < 55)
                f = FN_TICK;
            else if (pick < 62)
                f = FN_SOFT_TOUCH;
            else if (pick < 65)
                f = FN_TOUCH_ALL;
            else if (pick < 70)
                f = FN_NMI_TOUCH;
            else if (pick < 80)
                f = FN_THREAD_RUN;
            else if (pick < 88)
                f = FN_ONLINE;
            else
                f = FN_OFFLINE;

            if ($urandom_range(0, 99) < 70)
                tk = task_t'($urandom_range(0, 3));
            else
                tk = task_t'($urandom());

            send_event(f, c, wall, tk, $urandom_range(0, 99) < 12);
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        int thresholds[6];
        int soft_en[6];
        int hard_en[6];
        int bt_en[6];
        thresholds = '{1, 60, 0, 5, 3, 7};
        soft_en    = '{1, 0, 1, 0, 1, 1};
        hard_en    = '{1, 1, 0, 0, 1, 0};
        bt_en      = '{1, 0, 1, 1, 0, 1};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 38 : (p < 4) ? 84 : 0;
            recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 38 : 0;
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thresholds[p]));
            write_reg(CFG_SOFT_PANIC, CFG_DATA_W'(soft_en[p]));
            write_reg(CFG_HARD_PANIC, CFG_DATA_W'(hard_en[p]));
            write_reg(CFG_BACKTRACE_ALL, CFG_DATA_W'(bt_en[p]));
            cfg_we <= 1'b0;
            @(posedge clk);
            random_phase(180, thresholds[p]);
        end

        repeat (4) @(posedge clk);
        if (tracker.pending() != 0)
            $error("%0d expected reports never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/mclw_pkg.sv
sv/mclw_engine.sv
sv/multi_cpu_lockup_watchdog.sv
tb/sv/tb_multi_cpu_lockup_watchdog.sv
